@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

@@ rtl/core/mnsva_pkg.sv @@
// Types and constants shared by the note stack voice assigner modules.
`default_nettype none
package mnsva_pkg;

    localparam int NUM_SLOTS = 4;
    localparam int PADDR_W = 5;
    localparam logic [7:0] MUTED = 8'h80;
    localparam logic [4:0] OMNI = 5'd16;

    localparam logic KIND_CV = 1'b0;
    localparam logic KIND_GATE = 1'b1;

    localparam logic [1:0] CODE_NOTE = 2'd0;
    localparam logic [1:0] CODE_RELEASE = 2'd1;
    localparam logic [1:0] CODE_FIRST_ON = 2'd2;
    localparam logic [1:0] CODE_ALL_OFF = 2'd3;

    localparam logic [1:0] ORD_LAST = 2'd0;
    localparam logic [1:0] ORD_LOW = 2'd1;
    localparam logic [1:0] ORD_HIGH = 2'd2;

    localparam logic [2:0] REG_CHANNEL = 3'd0;
    localparam logic [2:0] REG_LOW_NOTE = 3'd1;
    localparam logic [2:0] REG_HIGH_NOTE = 3'd2;
    localparam logic [2:0] REG_MIN_VEL = 3'd3;
    localparam logic [2:0] REG_ASSIGN = 3'd4;

    // Command broadcast to every cell of the stack for one cycle.
    typedef struct packed {
        logic       clear;
        logic       ins;
        logic       del;
        logic [1:0] order;
        logic [6:0] note;
    } stack_op_t;

endpackage
`default_nettype wire

@@ rtl/core/midi_note_stack_voice_assigner.sv @@
// Top level of the MIDI note stack voice assigner: control, slots, register port.
// Sequence: a word is filtered and applied to the stack in ST_UPD, the slot plan is
// built in ST_PLAN, and ST_EMIT walks at most 9 candidates and sends the selected
// ones as events, each waiting for a free output register. A new word is taken
// only when the sequencer is back in idle.
// Reset (rst_n low, asynchronous) empties the stack, mutes all slots, loads defaults.
`default_nettype none
module midi_note_stack_voice_assigner #(
    parameter int STACK_DEPTH = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            mode,
    input  logic [3:0]                      channel,
    input  logic [6:0]                      note_number,
    input  logic [6:0]                      velocity,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            event_kind,
    output logic [1:0]                      event_code,
    output logic [1:0]                      slot,
    output logic [7:0]                      slot_value,
    output logic                            last,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mnsva_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import mnsva_pkg::*;

    // Sequencer: take a word, update the stack, plan the events, then emit them.
    typedef enum logic [1:0] {ST_IDLE, ST_UPD, ST_PLAN, ST_EMIT} state_t;
    // Each plan names a fixed list of candidate events; a mask picks those sent.
    typedef enum logic [1:0] {P_ALLOFF, P_NOTE, P_PARA} plan_t;

    state_t      state_reg, state_next;
    plan_t       plan_reg, plan_next;

    logic [4:0]  chan_cfg_reg;
    logic [6:0]  low_cfg_reg;
    logic [6:0]  high_cfg_reg;
    logic [6:0]  minv_cfg_reg;
    logic [2:0]  assign_cfg_reg;

    logic        in_mode_reg, in_mode_next;
    logic [3:0]  in_chan_reg, in_chan_next;
    logic [6:0]  in_note_reg, in_note_next;
    logic [6:0]  in_vel_reg, in_vel_next;
    logic        ok_reg, ok_next;

    logic [7:0]  slot_reg [NUM_SLOTS];
    logic [7:0]  slot_next [NUM_SLOTS];
    logic [1:0]  ptr_reg, ptr_next;
    logic [1:0]  pslot_reg, pslot_next;
    logic [8:0]  rem_reg, rem_next;
    logic [3:0]  k_reg, k_next;

    logic        out_valid_reg, out_valid_next;
    logic        out_kind_reg, out_kind_next;
    logic [1:0]  out_code_reg, out_code_next;
    logic [1:0]  out_slot_reg, out_slot_next;
    logic [7:0]  out_value_reg, out_value_next;
    logic        out_last_reg, out_last_next;

    stack_op_t   op;
    logic [6:0]  top_note [NUM_SLOTS];
    logic        top_valid [NUM_SLOTS];

    // Candidate event at the current walk position.
    logic        ev_kind;
    logic [1:0]  ev_code;
    logic [1:0]  ev_slot;
    logic [8:0]  ev_bit;

    // Plan-state helpers.
    logic        vel_on;
    logic        is_stack_mode;
    logic        para_changed;
    logic        para_any;
    logic [6:0]  para_n;
    logic [2:0]  cyc_size;
    logic [2:0]  ptr_inc;
    logic        chan_ok;

    mnsva_stack #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (op),
        .top_note  (top_note),
        .top_valid (top_valid)
    );

    // Register port: writes never wait (pready is tied high), reads come straight from the registers.
    assign pready = 1'b1;

    always_comb
    begin
        unique case (paddr[PADDR_W-1:2])
            REG_CHANNEL:   prdata = {27'd0, chan_cfg_reg};
            REG_LOW_NOTE:  prdata = {25'd0, low_cfg_reg};
            REG_HIGH_NOTE: prdata = {25'd0, high_cfg_reg};
            REG_MIN_VEL:   prdata = {25'd0, minv_cfg_reg};
            REG_ASSIGN:    prdata = {29'd0, assign_cfg_reg};
            default:       prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_cfg_reg <= OMNI;
            low_cfg_reg <= 7'd0;
            high_cfg_reg <= 7'd127;
            minv_cfg_reg <= 7'd0;
            assign_cfg_reg <= 3'd0;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[PADDR_W-1:2])
                REG_CHANNEL:   chan_cfg_reg <= pwdata[4:0];
                REG_LOW_NOTE:  low_cfg_reg <= pwdata[6:0];
                REG_HIGH_NOTE: high_cfg_reg <= pwdata[6:0];
                REG_MIN_VEL:   minv_cfg_reg <= pwdata[6:0];
                REG_ASSIGN:    assign_cfg_reg <= pwdata[2:0];
                default:       ;
            endcase
        end
    end

    // Input is taken whenever the sequencer is idle, even while the output
    // register still holds the final word of the previous item.
    assign in_ready = (state_reg == ST_IDLE);

    assign vel_on = |in_vel_reg;
    // Mono (last, low, high) and both paraphonic modes work on the stack.
    assign is_stack_mode = (assign_cfg_reg <= 3'd2) || (assign_cfg_reg >= 3'd6);
    assign chan_ok = (chan_cfg_reg == OMNI) || (chan_cfg_reg == {1'b0, in_chan_reg});
    assign cyc_size = assign_cfg_reg - 3'd1;
    assign ptr_inc = {1'b0, ptr_reg} + 3'd1;

    // Decode the candidate event for the walk position.
    always_comb
    begin
        ev_bit = 9'(1) << k_reg;
        ev_kind = KIND_GATE;
        ev_code = CODE_NOTE;
        ev_slot = 2'd0;
        unique case (plan_reg)
            P_ALLOFF:
            begin
                if (k_reg < 4'd4)
                begin
                    ev_code = CODE_RELEASE;
                    ev_slot = k_reg[1:0];
                end
                else
                begin
                    ev_code = CODE_ALL_OFF;
                end
            end
            P_NOTE:
            begin
                if (k_reg == 4'd0)
                begin
                    ev_kind = KIND_CV;
                    ev_slot = pslot_reg;
                end
                else if (k_reg == 4'd1)
                begin
                    ev_slot = pslot_reg;
                end
                else
                begin
                    ev_code = CODE_FIRST_ON;
                end
            end
            default:
            begin
                if (k_reg == 4'd8)
                begin
                    ev_code = CODE_FIRST_ON;
                end
                else
                begin
                    ev_kind = k_reg[0] ? KIND_GATE : KIND_CV;
                    ev_slot = k_reg[2:1];
                end
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        plan_next = plan_reg;
        in_mode_next = in_mode_reg;
        in_chan_next = in_chan_reg;
        in_note_next = in_note_reg;
        in_vel_next = in_vel_reg;
        ok_next = ok_reg;
        slot_next = slot_reg;
        ptr_next = ptr_reg;
        pslot_next = pslot_reg;
        rem_next = rem_reg;
        k_next = k_reg;
        out_kind_next = out_kind_reg;
        out_code_next = out_code_reg;
        out_slot_next = out_slot_reg;
        out_value_next = out_value_reg;
        out_last_next = out_last_reg;
        out_valid_next = out_valid_reg && !out_ready;
        op = '0;
        para_changed = 1'b0;
        para_any = 1'b0;
        para_n = 7'd0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    in_mode_next = mode;
                    in_chan_next = channel;
                    in_note_next = note_number;
                    in_vel_next = velocity;
                    state_next = ST_UPD;
                end
            end
            ST_UPD:
            begin
                // Filter the message and apply it to the stack in the same cycle.
                ok_next = chan_ok && (in_note_reg >= low_cfg_reg)
                    && (in_note_reg <= high_cfg_reg)
                    && !(vel_on && (minv_cfg_reg != 7'd0) && (in_vel_reg < minv_cfg_reg));
                op.note = in_note_reg;
                op.order = (assign_cfg_reg >= 3'd6) ? ORD_LOW : assign_cfg_reg[1:0];
                op.clear = in_mode_reg;
                op.ins = !in_mode_reg && ok_next && is_stack_mode && vel_on;
                op.del = !in_mode_reg && ok_next && is_stack_mode && !vel_on;
                state_next = ST_PLAN;
            end
            ST_PLAN:
            begin
                k_next = 4'd0;
                rem_next = 9'd0;
                plan_next = P_ALLOFF;
                pslot_next = 2'd0;
                state_next = ST_EMIT;
                if (in_mode_reg)
                begin
                    for (int i = 0; i < NUM_SLOTS; i++)
                    begin
                        slot_next[i] = MUTED;
                    end
                    ptr_next = 2'd0;
                    rem_next = 9'b0_0001_1111;
                end
                else if (ok_reg)
                begin
                    if (assign_cfg_reg <= 3'd2)
                    begin
                        // Mono: the top of the stack drives slot zero.
                        if (!top_valid[0])
                        begin
                            if (slot_reg[0] != MUTED)
                            begin
                                slot_next[0] = MUTED;
                                rem_next = 9'b0_0001_1111;
                            end
                        end
                        else if (slot_reg[0] != {1'b0, top_note[0]})
                        begin
                            slot_next[0] = {1'b0, top_note[0]};
                            plan_next = P_NOTE;
                            rem_next = {6'd0, slot_reg[0] == MUTED, 2'b11};
                        end
                    end
                    else if (assign_cfg_reg <= 3'd5)
                    begin
                        // Cycle: a note-on takes the pointed slot, a note-off
                        // releases every slot that plays the note.
                        if (vel_on)
                        begin
                            slot_next[ptr_reg] = {1'b0, in_note_reg};
                            plan_next = P_NOTE;
                            pslot_next = ptr_reg;
                            rem_next = 9'b0_0000_0111;
                            ptr_next = (ptr_inc >= cyc_size) ? 2'd0 : ptr_inc[1:0];
                        end
                        else
                        begin
                            for (int i = 0; i < NUM_SLOTS; i++)
                            begin
                                if (slot_reg[i] == {1'b0, in_note_reg})
                                begin
                                    slot_next[i] = MUTED;
                                    rem_next[i] = 1'b1;
                                end
                                else if (slot_reg[i] != MUTED)
                                begin
                                    para_any = 1'b1;
                                end
                            end
                            rem_next[4] = !para_any;
                        end
                    end
                    else if (top_valid[0] && (vel_on || (assign_cfg_reg == 3'd6)))
                    begin
                        // Paraphonic: the ascending stack repeats round the slots.
                        plan_next = P_PARA;
                        for (int i = 0; i < NUM_SLOTS; i++)
                        begin
                            if (top_valid[i])
                            begin
                                para_n = top_note[i];
                            end
                            else if (!top_valid[2] && top_valid[1])
                            begin
                                para_n = top_note[i % 2];
                            end
                            else
                            begin
                                para_n = top_note[0];
                            end
                            if (slot_reg[i] != {1'b0, para_n})
                            begin
                                para_changed = 1'b1;
                                rem_next[2*i] = 1'b1;
                            end
                            slot_next[i] = {1'b0, para_n};
                            rem_next[2*i+1] = para_changed
                                || (vel_on && (para_n == in_note_reg));
                        end
                        rem_next[8] = vel_on;
                    end
                    else
                    begin
                        for (int i = 0; i < NUM_SLOTS; i++)
                        begin
                            slot_next[i] = MUTED;
                        end
                        rem_next = 9'b0_0001_1111;
                    end
                end
            end
            default:
            begin
                // Walk the candidates; a selected one waits for a free output register.
                if (rem_reg == 9'd0)
                begin
                    state_next = ST_IDLE;
                end
                else if ((rem_reg & ev_bit) == 9'd0)
                begin
                    k_next = k_reg + 4'd1;
                end
                else if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next = ev_kind;
                    out_code_next = ev_code;
                    out_slot_next = ev_slot;
                    out_value_next = ((ev_code == CODE_NOTE) || (ev_code == CODE_RELEASE))
                        ? slot_reg[ev_slot] : 8'd0;
                    out_last_next = ((rem_reg & ~ev_bit) == 9'd0);
                    rem_next = rem_reg & ~ev_bit;
                    k_next = k_reg + 4'd1;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            plan_reg <= P_ALLOFF;
            in_mode_reg <= 1'b0;
            in_chan_reg <= 4'd0;
            in_note_reg <= 7'd0;
            in_vel_reg <= 7'd0;
            ok_reg <= 1'b0;
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                slot_reg[i] <= MUTED;
            end
            ptr_reg <= 2'd0;
            pslot_reg <= 2'd0;
            rem_reg <= 9'd0;
            k_reg <= 4'd0;
            out_valid_reg <= 1'b0;
            out_kind_reg <= 1'b0;
            out_code_reg <= 2'd0;
            out_slot_reg <= 2'd0;
            out_value_reg <= 8'd0;
            out_last_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            plan_reg <= plan_next;
            in_mode_reg <= in_mode_next;
            in_chan_reg <= in_chan_next;
            in_note_reg <= in_note_next;
            in_vel_reg <= in_vel_next;
            ok_reg <= ok_next;
            slot_reg <= slot_next;
            ptr_reg <= ptr_next;
            pslot_reg <= pslot_next;
            rem_reg <= rem_next;
            k_reg <= k_next;
            out_valid_reg <= out_valid_next;
            out_kind_reg <= out_kind_next;
            out_code_reg <= out_code_next;
            out_slot_reg <= out_slot_next;
            out_value_reg <= out_value_next;
            out_last_reg <= out_last_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign event_kind = out_kind_reg;
    assign event_code = out_code_reg;
    assign slot = out_slot_reg;
    assign slot_value = out_value_reg;
    assign last = out_last_reg;

endmodule
`default_nettype wire

@@ rtl/core/mnsva_cell.sv @@
// One cell of the held-note stack: holds one note and shifts with its neighbors.
`default_nettype none
module mnsva_cell (
    input  logic                  clk,
    input  logic                  rst_n,
    input  mnsva_pkg::stack_op_t  op,
    input  logic [6:0]            left_note,
    input  logic                  left_valid,
    input  logic                  left_passed,
    input  logic [6:0]            right_note,
    input  logic                  right_valid,
    output logic [6:0]            note,
    output logic                  valid,
    output logic                  passed
);
    import mnsva_pkg::*;

    logic [6:0] note_reg;
    logic [6:0] note_next;
    logic       valid_reg;
    logic       valid_next;
    logic       hit;

    // An insert lands in the first cell that is empty or ranks below the new note.
    always_comb
    begin
        hit = 1'b0;
        if (op.ins)
        begin
            hit = !valid_reg || (op.order == ORD_LAST)
                || ((op.order == ORD_LOW) && (op.note < note_reg))
                || ((op.order == ORD_HIGH) && (op.note > note_reg));
        end
        else if (op.del)
        begin
            hit = valid_reg && (note_reg == op.note);
        end
    end

    assign passed = left_passed | hit;

    always_comb
    begin
        note_next = note_reg;
        valid_next = valid_reg;
        if (op.clear)
        begin
            valid_next = 1'b0;
        end
        else if (op.ins)
        begin
            valid_next = valid_reg | left_valid;
            if (left_passed)
            begin
                note_next = left_note;
            end
            else if (hit)
            begin
                note_next = op.note;
            end
        end
        else if (op.del)
        begin
            if (passed)
            begin
                note_next = right_note;
                valid_next = right_valid;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        note_reg <= note_next;
    end

    assign note = note_reg;
    assign valid = valid_reg;

endmodule
`default_nettype wire

@@ rtl/core/mnsva_stack.sv @@
// Held-note stack built as a row of cells, best note in cell zero.
`default_nettype none
module mnsva_stack #(
    parameter int STACK_DEPTH = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  mnsva_pkg::stack_op_t  op,
    output logic [6:0]            top_note [mnsva_pkg::NUM_SLOTS],
    output logic                  top_valid [mnsva_pkg::NUM_SLOTS]
);
    import mnsva_pkg::*;

    logic [6:0] note_w [STACK_DEPTH];
    logic       valid_w [STACK_DEPTH];
    logic       passed_w [STACK_DEPTH];

    genvar i;
    generate
        for (i = 0; i < STACK_DEPTH; i++)
        begin : g_cell
            logic [6:0] ln;
            logic       lv;
            logic       lp;
            logic [6:0] rn;
            logic       rv;
            if (i == 0)
            begin : g_first
                assign ln = 7'd0;
                assign lv = 1'b1;
                assign lp = 1'b0;
            end
            else
            begin : g_mid_l
                assign ln = note_w[i-1];
                assign lv = valid_w[i-1];
                assign lp = passed_w[i-1];
            end
            if (i == STACK_DEPTH - 1)
            begin : g_end
                assign rn = 7'd0;
                assign rv = 1'b0;
            end
            else
            begin : g_mid_r
                assign rn = note_w[i+1];
                assign rv = valid_w[i+1];
            end
            mnsva_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .op          (op),
                .left_note   (ln),
                .left_valid  (lv),
                .left_passed (lp),
                .right_note  (rn),
                .right_valid (rv),
                .note        (note_w[i]),
                .valid       (valid_w[i]),
                .passed      (passed_w[i])
            );
        end
        for (i = 0; i < NUM_SLOTS; i++)
        begin : g_top
            if (i < STACK_DEPTH)
            begin : g_have
                assign top_note[i] = note_w[i];
                assign top_valid[i] = valid_w[i];
            end
            else
            begin : g_none
                assign top_note[i] = 7'd0;
                assign top_valid[i] = 1'b0;
            end
        end
    endgenerate

endmodule
`default_nettype wire

@@ rtl/core/mnsva_checker.sv @@
// Port-level checker for the note stack voice assigner, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module mnsva_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  logic                            event_kind,
    input  logic [1:0]                      event_code,
    input  logic [1:0]                      slot,
    input  logic [7:0]                      slot_value,
    input  logic                            last
);
    import mnsva_pkg::*;

    // A stalled output word holds its contents.
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(event_code) && $stable(slot) && $stable(slot_value) && $stable(last))

    // After a word is taken in, the block is busy in the following cycle.
    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)

    // While more words of the same item remain, no new item is taken.
    `ASSERT_NEXT(a_no_accept_midway, clk, rst_n, out_valid && out_ready && !last, !in_ready)

    // All-notes-off and first-note-on are gate events that name no slot.
    `ASSERT_SAME(a_global_event, clk, rst_n, out_valid && ((event_code == CODE_ALL_OFF) || (event_code == CODE_FIRST_ON)), (event_kind == KIND_GATE) && (slot == 2'd0) && (slot_value == 8'd0))

endmodule

bind midi_note_stack_voice_assigner mnsva_checker u_mnsva_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .event_kind (event_kind),
    .event_code (event_code),
    .slot       (slot),
    .slot_value (slot_value),
    .last       (last)
);
`default_nettype wire

@@ dv/midi_note_stack_voice_assigner_tb.sv @@
// Testbench for the MIDI note stack voice assigner: predicted event stream checked per word.
`timescale 1ns / 100ps
`default_nettype none
module midi_note_stack_voice_assigner_tb;
    import mnsva_pkg::*;

    localparam int DEPTH = 8;

    // One note message or reset command as offered on the input channel.
    typedef struct packed {
        logic       mode;
        logic [3:0] channel;
        logic [6:0] note;
        logic [6:0] velocity;
    } note_msg_t;

    // One event word as it leaves the block.
    typedef struct packed {
        logic       kind;
        logic [1:0] code;
        logic [1:0] slot;
        logic [7:0] value;
        logic       last;
    } voice_event_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic mode;
    logic [3:0] channel;
    logic [6:0] note_number;
    logic [6:0] velocity;
    logic out_valid;
    logic out_ready;
    logic event_kind;
    logic [1:0] event_code;
    logic [1:0] slot;
    logic [7:0] slot_value;
    logic last;
    logic psel;
    logic penable;
    logic pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    midi_note_stack_voice_assigner #(.STACK_DEPTH(DEPTH)) u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .mode(mode), .channel(channel), .note_number(note_number), .velocity(velocity),
        .out_valid(out_valid), .out_ready(out_ready),
        .event_kind(event_kind), .event_code(event_code), .slot(slot),
        .slot_value(slot_value), .last(last),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // The clock runs free for the whole simulation.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Shadow copy of the registers and of the block's voice state. The predictor
    // works on these whenever the driver hands over a word.
    logic [4:0] cfg_channel;
    logic [6:0] cfg_low;
    logic [6:0] cfg_high;
    logic [6:0] cfg_min_vel;
    logic [2:0] cfg_assign;
    logic [6:0] held [DEPTH];
    int         held_cnt;
    logic [7:0] slots [NUM_SLOTS];
    int         cyc_ptr;

    note_msg_t    pending_msgs[$];
    voice_event_t expected_events[$];
    int           error_count;
    int           words_sent;
    bit           stim_done;
    bit           long_hold;

    task automatic report_mismatch(input string what);
        begin
            error_count++;
            $display("%0t: mismatch: %s", $realtime, what);
        end
    endtask

    // Queues one expected event; slot and value are zero unless the event names a slot.
    function automatic void push_event(input logic kind, input logic [1:0] code,
                                       input int s);
        voice_event_t ev;
        bit slotted;
        slotted = (code == CODE_NOTE || code == CODE_RELEASE);
        ev.kind = kind;
        ev.code = code;
        ev.slot = slotted ? 2'(s) : 2'd0;
        ev.value = slotted ? slots[s] : 8'd0;
        ev.last = 1'b0;
        expected_events.push_back(ev);
    endfunction

    function automatic void push_all_off();
        for (int i = 0; i < NUM_SLOTS; i++)
            push_event(KIND_GATE, CODE_RELEASE, i);
        push_event(KIND_GATE, CODE_ALL_OFF, 0);
    endfunction

    // Inserts or removes one note in the held stack under the given ordering.
    function automatic void update_held(input logic [6:0] n, input logic [6:0] vel,
                                        input logic [1:0] order);
        int pos;
        int i;
        if (vel != 0)
        begin
            for (pos = 0; pos < held_cnt; pos++)
            begin
                if (order == ORD_LAST || (order == ORD_LOW && n < held[pos]) ||
                    (order == ORD_HIGH && n > held[pos]))
                    break;
            end
            if (held_cnt < DEPTH)
                held_cnt++;
            if (pos < held_cnt)
            begin
                for (i = held_cnt - 1; i > pos; i--)
                    held[i] = held[i - 1];
                held[pos] = n;
            end
        end
        else
        begin
            for (i = 0; i < held_cnt; i++)
            begin
                if (held[i] == n)
                begin
                    held_cnt--;
                    for (int j = i; j < held_cnt; j++)
                        held[j] = held[j + 1];
                    break;
                end
            end
        end
    endfunction

    // Works out every event that one accepted word causes and queues them in order.
    function automatic void predict_voice_events(input note_msg_t m);
        int first_idx;
        bit pass;
        logic [7:0] prev;
        bit any_live;
        bit changed;
        logic [7:0] n;
        int p;
        first_idx = expected_events.size();
        if (m.mode)
        begin
            held_cnt = 0;
            cyc_ptr = 0;
            for (int i = 0; i < NUM_SLOTS; i++)
                slots[i] = MUTED;
            push_all_off();
        end
        else
        begin
            pass = (cfg_channel == OMNI || cfg_channel == {1'b0, m.channel});
            if (m.note < cfg_low || m.note > cfg_high)
                pass = 0;
            if (m.velocity != 0 && cfg_min_vel != 0 && m.velocity < cfg_min_vel)
                pass = 0;
            if (pass && cfg_assign <= 3'd2)
            begin
                // Mono: the top of the stack drives slot 0.
                update_held(m.note, m.velocity, cfg_assign[1:0]);
                prev = slots[0];
                if (held_cnt == 0)
                begin
                    if (prev != MUTED)
                    begin
                        slots[0] = MUTED;
                        push_all_off();
                    end
                end
                else if (prev != {1'b0, held[0]})
                begin
                    slots[0] = {1'b0, held[0]};
                    push_event(KIND_CV, CODE_NOTE, 0);
                    push_event(KIND_GATE, CODE_NOTE, 0);
                    if (prev == MUTED)
                        push_event(KIND_GATE, CODE_FIRST_ON, 0);
                end
            end
            else if (pass && cfg_assign <= 3'd5)
            begin
                // Cycle: a note on takes the slot under the pointer, a note off
                // releases every slot that holds that note.
                if (m.velocity != 0)
                begin
                    p = cyc_ptr & 3;
                    slots[p] = {1'b0, m.note};
                    push_event(KIND_CV, CODE_NOTE, p);
                    push_event(KIND_GATE, CODE_NOTE, p);
                    push_event(KIND_GATE, CODE_FIRST_ON, 0);
                    p++;
                    cyc_ptr = (p >= int'(cfg_assign) - 1) ? 0 : p;
                end
                else
                begin
                    any_live = 0;
                    for (int i = 0; i < NUM_SLOTS; i++)
                    begin
                        if (slots[i] == {1'b0, m.note})
                        begin
                            slots[i] = MUTED;
                            push_event(KIND_GATE, CODE_RELEASE, i);
                        end
                        else if (slots[i] != MUTED)
                            any_live = 1;
                    end
                    if (!any_live)
                        push_event(KIND_GATE, CODE_ALL_OFF, 0);
                end
            end
            else if (pass)
            begin
                // Paraphonic: ascending stack copied round the slots.
                update_held(m.note, m.velocity, ORD_LOW);
                if (held_cnt != 0 && (m.velocity != 0 || cfg_assign == 3'd6))
                begin
                    changed = 0;
                    for (int i = 0; i < NUM_SLOTS; i++)
                    begin
                        n = {1'b0, held[i % held_cnt]};
                        if (slots[i] != n)
                        begin
                            slots[i] = n;
                            changed = 1;
                            push_event(KIND_CV, CODE_NOTE, i);
                        end
                        if (changed || (m.velocity != 0 && n == {1'b0, m.note}))
                            push_event(KIND_GATE, CODE_NOTE, i);
                    end
                    if (m.velocity != 0)
                        push_event(KIND_GATE, CODE_FIRST_ON, 0);
                end
                else
                begin
                    for (int i = 0; i < NUM_SLOTS; i++)
                        slots[i] = MUTED;
                    push_all_off();
                end
            end
        end
        if (expected_events.size() > first_idx)
            expected_events[expected_events.size() - 1].last = 1'b1;
    endfunction

    // Driver: bursts of words separated by random gaps. A word stays on the
    // port until it is accepted; the predictor runs at that edge.
    int burst_left;
    int gap_left;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            burst_left = 0;
            gap_left = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                predict_voice_events(pending_msgs.pop_front());
                words_sent++;
            end
            if (!(in_valid && !in_ready))
            begin
                if (burst_left == 0 && gap_left == 0)
                begin
                    burst_left = $urandom_range(1, 12);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
                end
                if (burst_left > 0 && pending_msgs.size() > 0)
                begin
                    burst_left--;
                    in_valid <= 1'b1;
                    mode <= pending_msgs[0].mode;
                    channel <= pending_msgs[0].channel;
                    note_number <= pending_msgs[0].note;
                    velocity <= pending_msgs[0].velocity;
                end
                else
                begin
                    in_valid <= 1'b0;
                    if (gap_left > 0)
                        gap_left--;
                end
            end
        end
    end

    // Monitor: the receiver stalls on its own pattern, or holds off entirely
    // while the long-hold flag is raised, and checks each accepted event.
    int stall_phase;
    voice_event_t got;
    voice_event_t want;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_phase = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got = '{event_kind, event_code, slot, slot_value, last};
                if (expected_events.size() == 0)
                    report_mismatch($sformatf("unexpected event %p", got));
                else
                begin
                    want = expected_events.pop_front();
                    if (got.kind !== want.kind)
                        report_mismatch($sformatf("event_kind %b want %b", got.kind, want.kind));
                    if (got.code !== want.code)
                        report_mismatch($sformatf("event_code %0d want %0d", got.code, want.code));
                    if (got.slot !== want.slot)
                        report_mismatch($sformatf("slot %0d want %0d", got.slot, want.slot));
                    if (got.value !== want.value)
                        report_mismatch($sformatf("slot_value %h want %h", got.value, want.value));
                    if (got.last !== want.last)
                        report_mismatch($sformatf("last %b want %b", got.last, want.last));
                end
            end
            stall_phase = (stall_phase + 1) % 23;
            if (long_hold)
                out_ready <= 1'b0;
            else if (stall_phase < 8)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(0, 2) != 0);
        end
    end

    // Register write over the APB-style port: setup cycle, then access cycle.
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        begin
            @(posedge clk);
            psel <= 1'b1;
            penable <= 1'b0;
            pwrite <= 1'b1;
            paddr <= PADDR_W'({idx, 2'b00});
            pwdata <= val;
            @(posedge clk);
            penable <= 1'b1;
            @(posedge clk);
            psel <= 1'b0;
            penable <= 1'b0;
            pwrite <= 1'b0;
            case (idx)
                REG_CHANNEL: cfg_channel = val[4:0];
                REG_LOW_NOTE: cfg_low = val[6:0];
                REG_HIGH_NOTE: cfg_high = val[6:0];
                REG_MIN_VEL: cfg_min_vel = val[6:0];
                default: cfg_assign = val[2:0];
            endcase
        end
    endtask

    function automatic note_msg_t make_msg(input logic md, input logic [3:0] ch,
                                           input logic [6:0] n, input logic [6:0] v);
        note_msg_t m;
        m.mode = md;
        m.channel = ch;
        m.note = n;
        m.velocity = v;
        return m;
    endfunction

    // Waits until every queued word went in and every event came out, then lets
    // the block's own pipeline drain before the registers may change.
    task automatic wait_idle();
        begin
            while (pending_msgs.size() != 0 || in_valid || expected_events.size() != 0)
                @(posedge clk);
            repeat (20) @(posedge clk);
        end
    endtask

    // Random phrase: mostly a small pool of notes so that note offs find their
    // notes, with a little noise of off-channel words and resets.
    task automatic queue_phrase(input int count, input logic [3:0] ch_hint);
        logic [6:0] pool [6];
        int r;
        begin
            for (int i = 0; i < 6; i++)
                pool[i] = 7'($urandom_range(0, 127));
            for (int i = 0; i < count; i++)
            begin
                r = $urandom_range(0, 99);
                if (r < 3)
                    pending_msgs.push_back(make_msg(1'b1, 4'($urandom), 7'($urandom),
                                                    7'($urandom)));
                else if (r < 10)
                    pending_msgs.push_back(make_msg(1'b0, 4'($urandom), 7'($urandom),
                                                    7'($urandom)));
                else
                    pending_msgs.push_back(make_msg(1'b0,
                        ($urandom_range(0, 5) == 0) ? 4'($urandom) : ch_hint,
                        pool[$urandom_range(0, 5)],
                        ($urandom_range(0, 1) == 0) ? 7'd0 : 7'($urandom_range(1, 127))));
            end
        end
    endtask

    logic [3:0] ch_pick;
    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        mode = 1'b0;
        channel = '0;
        note_number = '0;
        velocity = '0;
        out_ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        error_count = 0;
        words_sent = 0;
        stim_done = 0;
        long_hold = 0;
        cfg_channel = OMNI;
        cfg_low = 7'd0;
        cfg_high = 7'd127;
        cfg_min_vel = 7'd0;
        cfg_assign = 3'd0;
        held_cnt = 0;
        cyc_ptr = 0;
        for (int i = 0; i < DEPTH; i++)
            held[i] = '0;
        for (int i = 0; i < NUM_SLOTS; i++)
            slots[i] = MUTED;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: mono-last with field extremes, a repeated note, a stack
        // overflow past its depth, a note off for an unheld note, and a reset.
        pending_msgs.push_back(make_msg(1'b0, 4'd15, 7'd127, 7'd127));
        pending_msgs.push_back(make_msg(1'b0, 4'd0, 7'd0, 7'd1));
        pending_msgs.push_back(make_msg(1'b0, 4'd0, 7'd0, 7'd64));
        pending_msgs.push_back(make_msg(1'b0, 4'd0, 7'd0, 7'd0));
        pending_msgs.push_back(make_msg(1'b0, 4'd3, 7'd55, 7'd0));
        for (int i = 0; i < 10; i++)
            pending_msgs.push_back(make_msg(1'b0, 4'd5, 7'(40 + i), 7'd90));
        pending_msgs.push_back(make_msg(1'b0, 4'd5, 7'd49, 7'd0));
        pending_msgs.push_back(make_msg(1'b1, 4'd15, 7'd127, 7'd127));
        pending_msgs.push_back(make_msg(1'b0, 4'd1, 7'd60, 7'd0));
        wait_idle();

        // Filters: a channel that cannot match, inverted note range, velocity threshold.
        write_reg(REG_CHANNEL, 32'd31);
        pending_msgs.push_back(make_msg(1'b0, 4'd15, 7'd60, 7'd100));
        wait_idle();
        write_reg(REG_CHANNEL, 32'd9);
        write_reg(REG_LOW_NOTE, 32'd100);
        write_reg(REG_HIGH_NOTE, 32'd20);
        pending_msgs.push_back(make_msg(1'b0, 4'd9, 7'd60, 7'd100));
        wait_idle();
        write_reg(REG_LOW_NOTE, 32'd30);
        write_reg(REG_HIGH_NOTE, 32'd90);
        write_reg(REG_MIN_VEL, 32'd127);
        pending_msgs.push_back(make_msg(1'b0, 4'd9, 7'd30, 7'd126));
        pending_msgs.push_back(make_msg(1'b0, 4'd9, 7'd90, 7'd127));
        pending_msgs.push_back(make_msg(1'b0, 4'd9, 7'd29, 7'd127));
        pending_msgs.push_back(make_msg(1'b0, 4'd8, 7'd50, 7'd127));
        pending_msgs.push_back(make_msg(1'b0, 4'd9, 7'd90, 7'd0));
        wait_idle();

        // Cycle over four slots, then shrink to two so the pointer sits past the end.
        write_reg(REG_CHANNEL, 32'd16);
        write_reg(REG_LOW_NOTE, 32'd0);
        write_reg(REG_HIGH_NOTE, 32'd127);
        write_reg(REG_MIN_VEL, 32'd0);
        write_reg(REG_ASSIGN, 32'd5);
        for (int i = 0; i < 3; i++)
            pending_msgs.push_back(make_msg(1'b0, 4'd2, 7'(70 + i), 7'd80));
        wait_idle();
        write_reg(REG_ASSIGN, 32'd3);
        pending_msgs.push_back(make_msg(1'b0, 4'd2, 7'd10, 7'd80));
        pending_msgs.push_back(make_msg(1'b0, 4'd2, 7'd11, 7'd80));
        pending_msgs.push_back(make_msg(1'b0, 4'd2, 7'd99, 7'd0));
        wait_idle();

        // Random phases, two per assignment mode, with several filter settings.
        for (int ph = 0; ph < 16; ph++)
        begin
            ch_pick = 4'($urandom);
            write_reg(REG_ASSIGN, 32'(ph % 8));
            write_reg(REG_CHANNEL, ($urandom_range(0, 2) == 0) ? 32'(ch_pick) : 32'd16);
            write_reg(REG_LOW_NOTE, ($urandom_range(0, 2) == 0) ? 32'($urandom_range(0, 40)) : 0);
            write_reg(REG_HIGH_NOTE, ($urandom_range(0, 2) == 0) ?
                      32'($urandom_range(80, 127)) : 127);
            write_reg(REG_MIN_VEL, ($urandom_range(0, 2) == 0) ? 32'($urandom_range(1, 60)) : 0);
            queue_phrase(19, ch_pick);
            if (ph == 5)
            begin
                // Hold the receiver off long enough for the block to stall its input.
                long_hold = 1;
                repeat (400) @(posedge clk);
                long_hold = 0;
            end
            wait_idle();
        end
        stim_done = 1;
    end

    // End of run: all words in, all events out, pipeline drained.
    initial
    begin
        wait (stim_done);
        repeat (30) @(posedge clk);
        if (error_count == 0 && expected_events.size() == 0)
            $display("midi_note_stack_voice_assigner_tb OK");
        else
            $display("midi_note_stack_voice_assigner_tb NOT OK");
        $finish;
    end

    // Watchdog for a block that hangs.
    initial
    begin
        #5ms;
        $display("midi_note_stack_voice_assigner_tb NOT OK");
        $finish;
    end

endmodule
`default_nettype wire
